### design/iss_pkg.sv
`timescale 1ns / 1ps

package iss_pkg;

    // default sizes of the store
    localparam int DEF_CAPACITY   = 16;
    localparam int DEF_DATA_WIDTH = 32;

    // fixed widths of the beat fields
    localparam int FUNC_W      = 3;
    localparam int POS_W       = 5;
    localparam int IO_DATA_W   = 32;
    localparam int COUNT_OUT_W = 5;
    localparam int STATUS_W    = 2;

    // operation codes
    typedef enum logic [FUNC_W-1:0] {
        FN_PUSH_FRONT = 3'd0,
        FN_PUSH_BACK  = 3'd1,
        FN_INSERT     = 3'd2,
        FN_POP_FRONT  = 3'd3,
        FN_POP_BACK   = 3'd4,
        FN_ERASE      = 3'd5,
        FN_READ       = 3'd6
    } t_func;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    // the move that the cell chain makes
    typedef enum logic [1:0] {
        MV_HOLD  = 2'd0,
        MV_OPEN  = 2'd1,
        MV_CLOSE = 2'd2
    } t_move;

endpackage

### design/indexed_sequence_store.sv
`timescale 1ns / 1ps

// indexed sequence store: a bounded ordered list of words with deque and
// indexed insert, erase and read operations.
// input channel: i_valid / o_stall with i_func, i_position, i_data_in.
//   a beat is taken at a clock edge with i_valid high and o_stall low.
// output channel: o_valid / i_stall with o_read_data, o_element_count,
//   o_status; one result beat for every input beat, in order.
// the result is registered and shown in the cycle after its input beat is taken.
// throughput: one beat per cycle while o_stall is low; every operation
//   completes with its own beat because the whole cell chain shifts in parallel.
// when the receiver stalls a shown result, the result register holds and o_stall rises
//   in the same cycle, so no further input beat is taken until it drains.
// element 0 is the front; an insert at or beyond the count appends, a full
//   store rejects pushes and inserts; pops, erases and reads on an empty store
//   report empty, and erase or read at or beyond the count reports out of range.
// reset: synchronous, active low; clears the count and the output valid.
//   cell contents are not cleared, they are only read once written.

module indexed_sequence_store
    import iss_pkg::*;
#(
    parameter int CAPACITY   = DEF_CAPACITY,
    parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [FUNC_W-1:0]      i_func,
    input  logic [POS_W-1:0]       i_position,
    input  logic [IO_DATA_W-1:0]   i_data_in,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [IO_DATA_W-1:0]   o_read_data,
    output logic [COUNT_OUT_W-1:0] o_element_count,
    output logic [STATUS_W-1:0]    o_status
);

    // widths of the count, of a cell index and of the position compare
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int IW   = $clog2(CAPACITY);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          r_out_valid;
    logic [IO_DATA_W-1:0] r_read_data;
    t_status       r_status;
    t_status       n_status;

    logic accept;
    logic full;
    logic empty;
    logic pos_ge;
    logic rd_hit;
    t_move         move;
    t_move         cell_move;
    logic [IW-1:0] idx;
    logic [IW-1:0] rd_idx;

    logic [DATA_WIDTH+IO_DATA_W-1:0]  din_ext;
    logic [DATA_WIDTH-1:0]            word;
    logic [DATA_WIDTH-1:0]            rd_word;
    logic [IO_DATA_W+DATA_WIDTH-1:0]  rd_ext;
    logic [COUNT_OUT_W+CW-1:0]        cnt_ext;

    logic [DATA_WIDTH-1:0] cell_q [CAPACITY];

    // a new beat only enters when the result register is free or draining
    assign o_stall = r_out_valid & i_stall;
    assign accept  = i_valid & ~o_stall;

    // input word cut or zero-extended to the element width
    assign din_ext = {{DATA_WIDTH{1'b0}}, i_data_in};
    assign word    = din_ext[DATA_WIDTH-1:0];

    assign full   = (r_count == CW'(CAPACITY));
    assign empty  = (r_count == '0);
    assign pos_ge = (CMPW'(i_position) >= CMPW'(r_count));
    assign rd_idx = IW'(i_position);

    // operation decode: one chain move, its gap index, new count and status
    always_comb begin
        n_status = ST_OK;
        n_count  = r_count;
        move     = MV_HOLD;
        idx      = '0;
        rd_hit   = 1'b0;
        unique case (i_func) inside
            FN_PUSH_FRONT, FN_PUSH_BACK, FN_INSERT: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    move    = MV_OPEN;
                    n_count = r_count + CW'(1);
                    if (i_func == FN_PUSH_FRONT) begin
                        idx = '0;
                    end else if (i_func == FN_PUSH_BACK || pos_ge) begin
                        // insert past the back appends
                        idx = IW'(r_count);
                    end else begin
                        idx = IW'(i_position);
                    end
                end
            end
            FN_POP_FRONT, FN_POP_BACK: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    move    = MV_CLOSE;
                    n_count = r_count - CW'(1);
                    idx     = (i_func == FN_POP_FRONT) ? '0 : IW'(r_count - CW'(1));
                end
            end
            FN_ERASE, FN_READ: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else if (pos_ge) begin
                    n_status = ST_RANGE;
                end else if (i_func == FN_ERASE) begin
                    move    = MV_CLOSE;
                    n_count = r_count - CW'(1);
                    idx     = IW'(i_position);
                end else begin
                    rd_hit = 1'b1;
                end
            end
            default: begin
                // unused code: no change, ok status
                n_status = ST_OK;
            end
        endcase
    end

    // the chain only moves on a taken beat
    assign cell_move = accept ? move : MV_HOLD;

    // row of storage cells, each linked to the neighbors it has; the front cell takes the word
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [DATA_WIDTH-1:0] left_q;
        logic [DATA_WIDTH-1:0] right_q;

        if (g == 0) begin : g_front
            assign left_q = word;
        end else begin : g_inner_l
            assign left_q = cell_q[g-1];
        end

        if (g == CAPACITY - 1) begin : g_back
            assign right_q = cell_q[g];
        end else begin : g_inner_r
            assign right_q = cell_q[g+1];
        end

        iss_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .IDX_W      (IW),
            .CELL_INDEX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_move  (cell_move),
            .i_idx   (idx),
            .i_word  (word),
            .i_left  (left_q),
            .i_right (right_q),
            .o_q     (cell_q[g])
        );
    end

    // read tap: only a position below the count selects a cell
    assign rd_word = rd_hit ? cell_q[rd_idx] : '0;
    assign rd_ext  = {{IO_DATA_W{1'b0}}, rd_word};

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_read_data <= rd_ext[IO_DATA_W-1:0];
            r_status    <= n_status;
        end
    end

    // the count register always matches the result on display
    assign cnt_ext         = {{COUNT_OUT_W{1'b0}}, r_count};
    assign o_element_count = cnt_ext[COUNT_OUT_W-1:0];
    assign o_valid         = r_out_valid;
    assign o_read_data     = r_read_data;
    assign o_status        = r_status;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("element count above capacity");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && !full && (i_func == FN_PUSH_FRONT || i_func == FN_PUSH_BACK
            || i_func == FN_INSERT)
        |=> r_count == $past(r_count) + CW'(1))
        else $error("accepted push did not grow the count");

    a_full_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && full && (i_func == FN_PUSH_FRONT || i_func == FN_PUSH_BACK
            || i_func == FN_INSERT)
        |=> r_count == $past(r_count) && o_status == ST_FULL)
        else $error("insert into a full store was not rejected");

    a_rd_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_OK |-> o_read_data == '0)
        else $error("read data not zero on a failed operation");
`endif

endmodule

### design/iss_cell.sv
`timescale 1ns / 1ps

module iss_cell
    import iss_pkg::*;
#(
    parameter int DATA_WIDTH = DEF_DATA_WIDTH,
    parameter int IDX_W      = 4,
    parameter int CELL_INDEX = 0
) (
    input  logic                  i_clk,
    input  t_move                 i_move,
    input  logic [IDX_W-1:0]      i_idx,
    input  logic [DATA_WIDTH-1:0] i_word,
    input  logic [DATA_WIDTH-1:0] i_left,
    input  logic [DATA_WIDTH-1:0] i_right,
    output logic [DATA_WIDTH-1:0] o_q
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_INDEX);

    logic [DATA_WIDTH-1:0] r_q;

    // open: cells above the gap take the left neighbor, the gap takes the word
    // close: cells from the gap upward take the right neighbor
    always_ff @(posedge i_clk) begin
        unique case (i_move)
            MV_OPEN: begin
                if (MY_IDX > i_idx) begin
                    r_q <= i_left;
                end else if (MY_IDX == i_idx) begin
                    r_q <= i_word;
                end
            end
            MV_CLOSE: begin
                if (MY_IDX >= i_idx) begin
                    r_q <= i_right;
                end
            end
            default: begin
                r_q <= r_q;
            end
        endcase
    end

    assign o_q = r_q;

endmodule

### test/tb.sv
`timescale 1ns / 1ps

module tb;
    import iss_pkg::*;

    localparam int CAPACITY = DEF_CAPACITY;

    // func code outside the enum, must behave as a no-op
    localparam logic [FUNC_W-1:0] FN_UNUSED = 3'd7;

    // traffic mix for the random phases
    localparam int MIX_GROW   = 0;
    localparam int MIX_SHRINK = 1;
    localparam int MIX_ANY    = 2;

    localparam int PHASE_COUNT = 18;
    localparam int PHASE_BEATS = 50;
    localparam int QUIET_BEATS = 100;

    // expected content of one result beat
    typedef struct {
        logic [IO_DATA_W-1:0]   read_data;
        logic [COUNT_OUT_W-1:0] element_count;
        t_status                status;
    } t_op_outcome;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_valid;
    logic                   o_stall;
    logic [FUNC_W-1:0]      i_func;
    logic [POS_W-1:0]       i_position;
    logic [IO_DATA_W-1:0]   i_data_in;
    logic                   o_valid;
    logic                   i_stall = 1'b0;
    logic [IO_DATA_W-1:0]   o_read_data;
    logic [COUNT_OUT_W-1:0] o_element_count;
    logic [STATUS_W-1:0]    o_status;

    // model of the stored sequence, front at index 0
    logic [IO_DATA_W-1:0] model_words[$];
    // results still owed by the block, oldest first
    t_op_outcome pending_outcomes[$];

    int fail_count    = 0;
    bit quiet         = 1'b0;  // no idling on either side while set
    int hold_request  = 0;     // long receiver hold asked by a test
    int hold_left     = 0;
    int stall_left    = 0;

    indexed_sequence_store u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_func          (i_func),
        .i_position      (i_position),
        .i_data_in       (i_data_in),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_read_data     (o_read_data),
        .o_element_count (o_element_count),
        .o_status        (o_status)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // idle length: mostly none, often short, sometimes long
    function automatic int pick_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // apply one accepted beat to the model and queue the expected result
    function automatic void predict_store_op(input logic [FUNC_W-1:0] func,
                                             input logic [POS_W-1:0] pos,
                                             input logic [IO_DATA_W-1:0] word);
        t_op_outcome res;
        int n;
        n = model_words.size();
        res.read_data = '0;
        res.status    = ST_OK;
        case (func) inside
            FN_PUSH_FRONT, FN_PUSH_BACK, FN_INSERT: begin
                if (n >= CAPACITY) begin
                    res.status = ST_FULL;
                end else if (func == FN_PUSH_FRONT) begin
                    model_words.insert(0, word);
                end else if (func == FN_PUSH_BACK || pos >= n) begin
                    // insert at or past the count appends
                    model_words.insert(n, word);
                end else begin
                    model_words.insert(pos, word);
                end
            end
            FN_POP_FRONT, FN_POP_BACK: begin
                if (n == 0) begin
                    res.status = ST_EMPTY;
                end else if (func == FN_POP_FRONT) begin
                    model_words.delete(0);
                end else begin
                    model_words.delete(n - 1);
                end
            end
            FN_ERASE, FN_READ: begin
                if (n == 0) begin
                    res.status = ST_EMPTY;
                end else if (pos >= n) begin
                    res.status = ST_RANGE;
                end else if (func == FN_ERASE) begin
                    model_words.delete(pos);
                end else begin
                    res.read_data = model_words[pos];
                end
            end
            default: ;  // unused code: nothing changes
        endcase
        res.element_count = COUNT_OUT_W'(model_words.size());
        pending_outcomes.insert(pending_outcomes.size(), res);
    endfunction

    // offer one beat after a random gap and hold it until taken;
    // entered and left right after a rising edge
    task automatic send_op(input logic [FUNC_W-1:0] func,
                           input logic [POS_W-1:0] pos,
                           input logic [IO_DATA_W-1:0] word);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_func     <= func;
        i_position <= pos;
        i_data_in  <= word;
        do @(posedge i_clk); while (!(i_valid === 1'b1 && o_stall === 1'b0));
        predict_store_op(func, pos, word);
    endtask

    // receiver stall: a long hold when asked, otherwise random bursts
    always @(posedge i_clk) begin
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            i_stall <= 1'b1;
            hold_left--;
        end else if (stall_left > 0) begin
            i_stall <= 1'b1;
            stall_left--;
        end else begin
            stall_left = pick_gap();
            if (stall_left > 0) begin
                i_stall <= 1'b1;
                stall_left--;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // compare every accepted result beat with the oldest expectation
    always @(posedge i_clk) begin
        t_op_outcome want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_stall === 1'b0) begin
            if (pending_outcomes.size() == 0) begin
                $error("result beat with nothing expected: read_data %0h count %0d status %0d",
                       o_read_data, o_element_count, o_status);
                fail_count++;
            end else begin
                want = pending_outcomes[0];
                pending_outcomes.delete(0);
                if (o_read_data !== want.read_data) begin
                    $error("read_data: expected %0h, got %0h", want.read_data, o_read_data);
                    fail_count++;
                end
                if (o_element_count !== want.element_count) begin
                    $error("element_count: expected %0d, got %0d",
                           want.element_count, o_element_count);
                    fail_count++;
                end
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    fail_count++;
                end
            end
        end
    end

    // every pop, erase and read on an empty store, plus the unused code
    task automatic test_empty_store();
        send_op(FN_POP_FRONT, 5'd0, $urandom());
        send_op(FN_POP_BACK, 5'd0, $urandom());
        send_op(FN_ERASE, 5'd0, $urandom());
        send_op(FN_READ, 5'd0, $urandom());
        send_op(FN_READ, '1, $urandom());
        send_op(FN_UNUSED, '1, '1);
    endtask

    // prepend, append, insert past the count, ranges, last-index erase,
    // single element pop
    task automatic test_indexed_edges();
        send_op(FN_PUSH_BACK, 5'd0, '0);
        send_op(FN_PUSH_FRONT, 5'd0, '1);
        send_op(FN_INSERT, 5'd0, 32'ha5a5_5a5a);    // index 0 prepends
        send_op(FN_INSERT, '1, 32'h0123_4567);      // far past count appends
        send_op(FN_INSERT, 5'd1, 32'h8000_0001);
        send_op(FN_READ, 5'd0, '0);
        send_op(FN_READ, 5'd4, '0);
        send_op(FN_READ, 5'd5, '0);                 // one past the back
        send_op(FN_ERASE, 5'd4, '0);                // back element
        send_op(FN_ERASE, '1, '0);
        send_op(FN_POP_FRONT, 5'd0, '0);
        send_op(FN_POP_BACK, 5'd0, '0);
        send_op(FN_ERASE, 5'd0, '0);
        send_op(FN_READ, 5'd0, '0);
        send_op(FN_POP_BACK, 5'd0, '0);             // last one leaves, count 0
    endtask

    // fill to capacity, every way of adding is refused, then drain a bit
    task automatic test_full_store();
        for (int k = 0; k < CAPACITY; k++) send_op(FN_PUSH_BACK, '0, $urandom());
        send_op(FN_PUSH_FRONT, 5'd0, $urandom());
        send_op(FN_PUSH_BACK, 5'd0, $urandom());
        send_op(FN_INSERT, 5'd3, $urandom());
        send_op(FN_READ, 5'd15, '0);
        send_op(FN_READ, 5'd16, '0);
        send_op(FN_ERASE, 5'd0, '0);
    endtask

    // receiver holds off for a long stretch while beats keep coming,
    // so the result register fills and the input stalls
    task automatic test_backpressure();
        quiet        = 1'b1;
        hold_request = 60;
        for (int k = 0; k < 10; k++) begin
            send_op(FN_READ, POS_W'($urandom_range(0, 20)), $urandom());
        end
        quiet = 1'b0;
    endtask

    function automatic logic [FUNC_W-1:0] pick_func(input int mix);
        int r;
        r = $urandom_range(0, 9);
        if (mix == MIX_ANY) return FUNC_W'($urandom_range(FN_PUSH_FRONT, FN_UNUSED));
        if (mix == MIX_GROW) begin
            case (r)
                0, 1, 2: return FN_PUSH_BACK;
                3, 4:    return FN_PUSH_FRONT;
                5, 6:    return FN_INSERT;
                7:       return FN_READ;
                8:       return FN_ERASE;
                default: return FN_POP_FRONT;
            endcase
        end
        case (r)
            0, 1:    return FN_POP_FRONT;
            2, 3:    return FN_POP_BACK;
            4, 5:    return FN_ERASE;
            6, 7:    return FN_READ;
            8:       return FN_INSERT;
            default: return FN_PUSH_FRONT;
        endcase
    endfunction

    // random beat: positions mostly inside 0..count, some anywhere
    task automatic send_random_op(input int mix);
        logic [POS_W-1:0] pos;
        if ($urandom_range(0, 9) < 8) pos = POS_W'($urandom_range(0, model_words.size()));
        else pos = POS_W'($urandom_range(0, 31));
        send_op(pick_func(mix), pos, $urandom());
    endtask

    // grow, shrink and mixed phases sweep the count between empty and full
    task automatic test_random_traffic();
        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            for (int k = 0; k < PHASE_BEATS; k++) send_random_op(ph % 3);
        end
    endtask

    // back-to-back beats with no idling on either side
    task automatic test_quiet_stretch();
        quiet = 1'b1;
        for (int k = 0; k < QUIET_BEATS; k++) send_random_op(MIX_ANY);
        quiet = 1'b0;
    endtask

    initial begin
        i_rst_n    <= 1'b0;
        i_valid    <= 1'b0;
        i_func     <= '0;
        i_position <= '0;
        i_data_in  <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_store();
        test_indexed_edges();
        test_full_store();
        test_backpressure();
        test_random_traffic();
        test_quiet_stretch();
        i_valid <= 1'b0;

        // drain outstanding results, then watch for stray beats
        while (pending_outcomes.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("[indexed_sequence_store] OK");
        end else begin
            $display("[indexed_sequence_store] ERROR");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("[indexed_sequence_store] ERROR");
        $finish;
    end

endmodule
